// ----- rtl/core/oriented_box_to_aabb_core_assert.svh -----
// Assertion macros used by the checker file of the bounds core.
`ifndef ORIENTED_BOX_TO_AABB_CORE_ASSERT_SVH
`define ORIENTED_BOX_TO_AABB_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define OBB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("oriented_box_to_aabb_core check failed");

// An implication that is checked in the same cycle.
`define OBB_ASSERT_IMP(lbl, ante, cons) \
  `OBB_ASSERT(lbl, (ante) |-> (cons))

`endif

// ----- rtl/core/obb2aabb_pkg.sv -----
// Types, widths and constants of the oriented box to axis-aligned bounds core.
package obb2aabb_pkg;

  // Field widths.
  localparam int CoordW = 32;
  localparam int ExtW   = 31;
  localparam int QuatW  = 32;
  localparam int KindW  = 2;

  // Internal widths of the datapath.
  localparam int ProdW  = 2 * QuatW;   // full quaternion product
  localparam int RndW   = ProdW - 30;  // product rounded to Q.30
  localparam int MatW   = RndW + 3;    // matrix entry before clamping
  localparam int MagW   = 31;          // clamped magnitude, 0 .. 1.0 in Q.30
  localparam int EProdW = ExtW + MagW; // extent times magnitude
  localparam int SumW   = 64;          // sum of three extent products
  localparam int HW     = SumW - 30;   // half size of the bounds per axis
  localparam int SatW   = HW + 2;      // center plus or minus half size

  // Pipeline depth: three stages build the matrix, three finish the bounds.
  localparam int RotStages = 3;
  localparam int PipeDepth = RotStages + 3;

  // Fixed-point constants.
  localparam logic [MagW-1:0]         Q30One    = MagW'(1073741824);
  localparam logic signed [MatW-1:0]  Q30OneM   = MatW'(1073741824);
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(536870912);
  localparam logic [SumW-1:0]         SumHalf   = SumW'(536870912);

  // Shape kind codes.
  localparam logic [KindW-1:0] KindBox     = 2'd0;
  localparam logic [KindW-1:0] KindSphere  = 2'd1;
  localparam logic [KindW-1:0] KindFrustum = 2'd2;
  localparam logic [KindW-1:0] KindSpare   = 2'd3;

  // One request: a bounding volume.
  typedef struct packed {
    logic [KindW-1:0]         shape_kind;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [ExtW-1:0]          extent_x;
    logic [ExtW-1:0]          extent_y;
    logic [ExtW-1:0]          extent_z;
    logic signed [QuatW-1:0]  rot_w;
    logic signed [QuatW-1:0]  rot_x;
    logic signed [QuatW-1:0]  rot_y;
    logic signed [QuatW-1:0]  rot_z;
  } req_t;

  // One result: world axis-aligned bounds.
  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
  } res_t;

  // Rotation quaternion.
  typedef struct packed {
    logic signed [QuatW-1:0] rot_w;
    logic signed [QuatW-1:0] rot_x;
    logic signed [QuatW-1:0] rot_y;
    logic signed [QuatW-1:0] rot_z;
  } quat_t;

  // Clamped absolute rotation matrix, indexed [row][column].
  typedef logic [2:0][2:0][MagW-1:0] mag_t;

endpackage

// ----- rtl/core/obb2aabb_rot.sv -----
// Three-stage pipeline from a quaternion to the clamped absolute rotation matrix.
module obb2aabb_rot
  import obb2aabb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  quat_t quat_i,
  output logic  valid_o,
  output mag_t  mag_o
);

  // Product slots.
  localparam int PXX = 0;
  localparam int PYY = 1;
  localparam int PZZ = 2;
  localparam int PXY = 3;
  localparam int PXZ = 4;
  localparam int PYZ = 5;
  localparam int PXW = 6;
  localparam int PYW = 7;
  localparam int PZW = 8;
  localparam int NumProd = 9;

  function automatic logic signed [ProdW-1:0] mul_q(input logic signed [QuatW-1:0] a,
                                                    input logic signed [QuatW-1:0] b);
    logic signed [ProdW-1:0] r;
    r = a * b;
    return r;
  endfunction

  function automatic logic [MagW-1:0] abs_clamp(input logic signed [MatW-1:0] m);
    logic [MatW-1:0] a;
    a = m[MatW-1] ? MatW'(-m) : MatW'(m);
    if (a > MatW'(Q30One)) begin
      return Q30One;
    end
    return a[MagW-1:0];
  endfunction

  logic [RotStages-1:0] valid_q;

  logic signed [ProdW-1:0] prod_d [NumProd];
  logic signed [ProdW-1:0] prod_q [NumProd];
  logic signed [RndW-1:0]  rnd_d  [NumProd];
  logic signed [RndW-1:0]  rnd_q  [NumProd];
  mag_t                    mag_d;
  mag_t                    mag_q;

  // Stage one: the nine quaternion products.
  always_comb begin
    prod_d[PXX] = mul_q(quat_i.rot_x, quat_i.rot_x);
    prod_d[PYY] = mul_q(quat_i.rot_y, quat_i.rot_y);
    prod_d[PZZ] = mul_q(quat_i.rot_z, quat_i.rot_z);
    prod_d[PXY] = mul_q(quat_i.rot_x, quat_i.rot_y);
    prod_d[PXZ] = mul_q(quat_i.rot_x, quat_i.rot_z);
    prod_d[PYZ] = mul_q(quat_i.rot_y, quat_i.rot_z);
    prod_d[PXW] = mul_q(quat_i.rot_x, quat_i.rot_w);
    prod_d[PYW] = mul_q(quat_i.rot_y, quat_i.rot_w);
    prod_d[PZW] = mul_q(quat_i.rot_z, quat_i.rot_w);
  end

  // Stage two: round each product to Q.30, half toward plus infinity.
  always_comb begin
    logic signed [ProdW-1:0] t;
    for (int k = 0; k < NumProd; k++) begin
      t = prod_q[k] + RoundHalf;
      rnd_d[k] = t[ProdW-1:30];
    end
  end

  // Stage three: matrix entries in row-vector convention, then magnitude and clamp.
  always_comb begin
    logic signed [MatW-1:0] exx, eyy, ezz, exy, exz, eyz, exw, eyw, ezw;
    exx = MatW'(rnd_q[PXX]);
    eyy = MatW'(rnd_q[PYY]);
    ezz = MatW'(rnd_q[PZZ]);
    exy = MatW'(rnd_q[PXY]);
    exz = MatW'(rnd_q[PXZ]);
    eyz = MatW'(rnd_q[PYZ]);
    exw = MatW'(rnd_q[PXW]);
    eyw = MatW'(rnd_q[PYW]);
    ezw = MatW'(rnd_q[PZW]);
    mag_d[0][0] = abs_clamp(Q30OneM - ((eyy + ezz) <<< 1));
    mag_d[0][1] = abs_clamp((exy + ezw) <<< 1);
    mag_d[0][2] = abs_clamp((exz - eyw) <<< 1);
    mag_d[1][0] = abs_clamp((exy - ezw) <<< 1);
    mag_d[1][1] = abs_clamp(Q30OneM - ((exx + ezz) <<< 1));
    mag_d[1][2] = abs_clamp((eyz + exw) <<< 1);
    mag_d[2][0] = abs_clamp((exz + eyw) <<< 1);
    mag_d[2][1] = abs_clamp((eyz - exw) <<< 1);
    mag_d[2][2] = abs_clamp(Q30OneM - ((exx + eyy) <<< 1));
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[RotStages-2:0], valid_i};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rnd_q  <= rnd_d;
    mag_q  <= mag_d;
  end

  assign valid_o = valid_q[RotStages-1];
  assign mag_o   = mag_q;

endmodule

// ----- rtl/core/oriented_box_to_aabb_core.sv -----
// Top level of the oriented box to axis-aligned bounds core.
//
// Each request is one bounding volume; after start is taken, result_valid_o
// pulses for one cycle with its world bounds on res_o. The pipeline is six register
// stages deep (quaternion products, rounding, matrix magnitudes, extent products,
// half-size sums, saturated bounds) and takes a request in every cycle, so busy stays
// low and results leave in request order at one per cycle. The receiver cannot stall
// and must take each result in the cycle it is shown. A box uses center, half extents
// and the quaternion; a sphere uses center and the radius in extent_x; a frustum and
// the unused kind code give all zeros. Bounds saturate to the Q16.16 range.
module oriented_box_to_aabb_core
  import obb2aabb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic result_valid_o,
  output res_t res_o
);

  // Number of stages a request's side data spends before the output stage.
  localparam int SideStages = PipeDepth - 1;

  // Fields that ride alongside the matrix pipeline.
  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic [2:0][CoordW-1:0]   center;
    logic [2:0][ExtW-1:0]     ext;
  } side_t;

  logic   accept;
  quat_t  quat;
  side_t  side_in;
  side_t  side_q [SideStages];
  logic   rot_valid;
  mag_t   mag;

  logic                     eprod_valid_q;
  logic [EProdW-1:0]        eprod_d [3][3];
  logic [EProdW-1:0]        eprod_q [3][3];
  logic                     half_valid_q;
  logic [HW-1:0]            half_d  [3];
  logic [HW-1:0]            half_q  [3];
  logic                     res_valid_q;
  res_t                     res_d;
  res_t                     res_q;

  // Never stalls: one request per cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign quat.rot_w = req_i.rot_w;
  assign quat.rot_x = req_i.rot_x;
  assign quat.rot_y = req_i.rot_y;
  assign quat.rot_z = req_i.rot_z;

  assign side_in.kind   = req_i.shape_kind;
  assign side_in.center = {req_i.center_z, req_i.center_y, req_i.center_x};
  assign side_in.ext    = {req_i.extent_z, req_i.extent_y, req_i.extent_x};

  // Rotation matrix magnitudes.
  obb2aabb_rot u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .quat_i (quat),
    .valid_o(rot_valid),
    .mag_o  (mag)
  );

  // Side data shift line, aligned with the datapath stages.
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_in;
    for (int s = 1; s < SideStages; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  // Stage four: each extent times each matrix magnitude in its row.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        eprod_d[i][j] = side_q[RotStages-1].ext[i] * mag[i][j];
      end
    end
  end

  // Stage five: half size per axis by kind.
  always_comb begin
    logic [SumW-1:0] s;
    for (int j = 0; j < 3; j++) begin
      s = SumW'(eprod_q[0][j]) + SumW'(eprod_q[1][j]) + SumW'(eprod_q[2][j]) + SumHalf;
      if (side_q[RotStages].kind == KindBox) begin
        half_d[j] = s[SumW-1:30];
      end else if (side_q[RotStages].kind == KindSphere) begin
        half_d[j] = HW'(side_q[RotStages].ext[0]);
      end else begin
        half_d[j] = '0;
      end
    end
  end

  // Stage six: center minus and plus half size, saturated; frustum and unused kind give zeros.
  always_comb begin
    logic signed [SatW-1:0] c, lo, hi;
    logic [2:0][CoordW-1:0] mins, maxs;
    for (int j = 0; j < 3; j++) begin
      c  = SatW'($signed(side_q[SideStages-1].center[j]));
      lo = c - $signed(SatW'(half_q[j]));
      hi = c + $signed(SatW'(half_q[j]));
      if (lo[SatW-1:CoordW-1] != {(SatW-CoordW+1){lo[SatW-1]}}) begin
        mins[j] = {lo[SatW-1], {(CoordW-1){!lo[SatW-1]}}};
      end else begin
        mins[j] = lo[CoordW-1:0];
      end
      if (hi[SatW-1:CoordW-1] != {(SatW-CoordW+1){hi[SatW-1]}}) begin
        maxs[j] = {hi[SatW-1], {(CoordW-1){!hi[SatW-1]}}};
      end else begin
        maxs[j] = hi[CoordW-1:0];
      end
    end
    if (side_q[SideStages-1].kind == KindFrustum || side_q[SideStages-1].kind == KindSpare) begin
      res_d = '0;
    end else begin
      res_d.min_x = mins[0];
      res_d.min_y = mins[1];
      res_d.min_z = mins[2];
      res_d.max_x = maxs[0];
      res_d.max_y = maxs[1];
      res_d.max_z = maxs[2];
    end
  end

  // Valid bits for the last three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eprod_valid_q <= 1'b0;
      half_valid_q  <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      eprod_valid_q <= rot_valid;
      half_valid_q  <= eprod_valid_q;
      res_valid_q   <= half_valid_q;
    end
  end

  // Datapath registers of the last three stages.
  always_ff @(posedge clk_i) begin
    eprod_q <= eprod_d;
    half_q  <= half_d;
    res_q   <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

endmodule

// ----- rtl/core/obb2aabb_checker.sv -----
// Port-level checker for the bounds core, bound to the top level.
`include "oriented_box_to_aabb_core_assert.svh"

module obb2aabb_checker
  import obb2aabb_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic result_valid_o,
  input res_t res_o
);

  logic empty_kind;
  logic bounds_ordered;

  // A request whose kind gives empty bounds.
  assign empty_kind = req_i.shape_kind == KindFrustum || req_i.shape_kind == KindSpare;

  // Each axis of the shown bounds is ordered.
  assign bounds_ordered = res_o.min_x <= res_o.max_x &&
                          res_o.min_y <= res_o.max_y &&
                          res_o.min_z <= res_o.max_z;

  // The core never holds requests off.
  `OBB_ASSERT(never_busy_a, !busy)

  // Every result comes from a request that was taken.
  `OBB_ASSERT_IMP(result_has_request_a, result_valid_o, $past(start && !busy, PipeDepth))

  // Frustum and unused kinds give all-zero bounds.
  `OBB_ASSERT_IMP(frustum_zero_a, result_valid_o && $past(empty_kind, PipeDepth), res_o == '0)

  // Minimum never exceeds maximum on any axis.
  `OBB_ASSERT_IMP(min_le_max_a, result_valid_o, bounds_ordered)

endmodule

bind oriented_box_to_aabb_core obb2aabb_checker u_obb2aabb_checker (.*);
